@@ design/sls_pkg.sv @@
// Package for the system lifecycle sequencer: codes, the transition table and the result type.
package sls_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int STATE_W     = 5;
	localparam int EVENT_W     = 5;
	localparam int TIME_W      = 32;
	localparam int REPORT_W    = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CRIT_TIMEOUT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESTART_DELAY = 2'd1;

	localparam logic [TIME_W-1:0] CRIT_TIMEOUT_RESET  = 32'd10000;
	localparam logic [TIME_W-1:0] RESTART_DELAY_RESET = 32'd2000;

	// Lifecycle states
	localparam logic [STATE_W-1:0] ST_POWER_ON       = 5'd0;
	localparam logic [STATE_W-1:0] ST_HW_INIT        = 5'd1;
	localparam logic [STATE_W-1:0] ST_CRIT           = 5'd2;
	localparam logic [STATE_W-1:0] ST_STORAGE_INIT   = 5'd3;
	localparam logic [STATE_W-1:0] ST_CONFIG_LOAD    = 5'd4;
	localparam logic [STATE_W-1:0] ST_SECURITY_INIT  = 5'd5;
	localparam logic [STATE_W-1:0] ST_SETUP          = 5'd6;
	localparam logic [STATE_W-1:0] ST_ERROR          = 5'd7;
	localparam logic [STATE_W-1:0] ST_NET_INIT       = 5'd8;
	localparam logic [STATE_W-1:0] ST_SERVICES_INIT  = 5'd9;
	localparam logic [STATE_W-1:0] ST_NET_CONNECT    = 5'd10;
	localparam logic [STATE_W-1:0] ST_WEB_INIT       = 5'd11;
	localparam logic [STATE_W-1:0] ST_DEGRADED       = 5'd12;
	localparam logic [STATE_W-1:0] ST_RUNNING        = 5'd13;
	localparam logic [STATE_W-1:0] ST_MAINT          = 5'd14;
	localparam logic [STATE_W-1:0] ST_SHUTDOWN       = 5'd15;
	localparam logic [STATE_W-1:0] ST_RESTART        = 5'd16;
	localparam logic [STATE_W-1:0] ST_NONE           = 5'd17;

	// Lifecycle events
	localparam logic [EVENT_W-1:0] EV_HW_OK          = 5'd0;
	localparam logic [EVENT_W-1:0] EV_HW_FAIL        = 5'd1;
	localparam logic [EVENT_W-1:0] EV_STORAGE_OK     = 5'd2;
	localparam logic [EVENT_W-1:0] EV_STORAGE_FAIL   = 5'd3;
	localparam logic [EVENT_W-1:0] EV_CFG_LOADED     = 5'd4;
	localparam logic [EVENT_W-1:0] EV_CFG_MISSING    = 5'd5;
	localparam logic [EVENT_W-1:0] EV_CFG_CORRUPT    = 5'd6;
	localparam logic [EVENT_W-1:0] EV_SEC_OK         = 5'd7;
	localparam logic [EVENT_W-1:0] EV_SEC_FAIL       = 5'd8;
	localparam logic [EVENT_W-1:0] EV_NETDRV_OK      = 5'd9;
	localparam logic [EVENT_W-1:0] EV_NETDRV_FAIL    = 5'd10;
	localparam logic [EVENT_W-1:0] EV_SVC_OK         = 5'd11;
	localparam logic [EVENT_W-1:0] EV_SVC_FAIL       = 5'd12;
	localparam logic [EVENT_W-1:0] EV_LINK_UP        = 5'd13;
	localparam logic [EVENT_W-1:0] EV_LINK_FAIL      = 5'd14;
	localparam logic [EVENT_W-1:0] EV_WEB_OK         = 5'd15;
	localparam logic [EVENT_W-1:0] EV_WEB_FAIL       = 5'd16;
	localparam logic [EVENT_W-1:0] EV_HEALTH_DEGR    = 5'd17;
	localparam logic [EVENT_W-1:0] EV_HEALTH_CRIT    = 5'd18;
	localparam logic [EVENT_W-1:0] EV_MAINT_ENTER    = 5'd19;
	localparam logic [EVENT_W-1:0] EV_SHUTDOWN_REQ   = 5'd20;
	localparam logic [EVENT_W-1:0] EV_RESTART_REQ    = 5'd21;
	localparam logic [EVENT_W-1:0] EV_HEALTH_OK      = 5'd22;
	localparam logic [EVENT_W-1:0] EV_MAINT_EXIT     = 5'd23;
	localparam logic [EVENT_W-1:0] EV_ERR_RECOVERED  = 5'd24;
	localparam logic [EVENT_W-1:0] EV_SETUP_DONE     = 5'd25;

	// Input op codes
	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Entry notices
	localparam logic [1:0] NOTE_NONE     = 2'd0;
	localparam logic [1:0] NOTE_SYS_ERR  = 2'd1;
	localparam logic [1:0] NOTE_BOOT_OK  = 2'd2;
	localparam logic [1:0] NOTE_SHUTDOWN = 2'd3;

	typedef struct packed {
		logic                found;
		logic [STATE_W-1:0]  dst;
	} hit_t;

	typedef struct packed {
		logic                accepted;
		logic [STATE_W-1:0]  src_state;
		logic [STATE_W-1:0]  dst_state;
		logic [STATE_W-1:0]  last_state;
		logic [REPORT_W-1:0] transitions_done;
		logic [REPORT_W-1:0] events_rejected;
		logic                operational;
		logic                healthy;
		logic                restart_now;
		logic [1:0]          entry_notice;
	} res_t;

	// Transition table; first matching row wins, and no (state, event) pair repeats.
	function automatic hit_t row_lookup(input logic [STATE_W-1:0] s,
	                                    input logic [EVENT_W-1:0] e);
		hit_t h;
		h.found = 1'b1;
		h.dst   = ST_POWER_ON;
		case ({s, e})
			{ST_POWER_ON, EV_HW_OK}:             h.dst = ST_HW_INIT;
			{ST_POWER_ON, EV_HW_FAIL}:           h.dst = ST_CRIT;
			{ST_HW_INIT, EV_HW_OK}:              h.dst = ST_STORAGE_INIT;
			{ST_HW_INIT, EV_HW_FAIL}:            h.dst = ST_CRIT;
			{ST_STORAGE_INIT, EV_STORAGE_OK}:    h.dst = ST_CONFIG_LOAD;
			{ST_STORAGE_INIT, EV_STORAGE_FAIL}:  h.dst = ST_CRIT;
			{ST_CONFIG_LOAD, EV_CFG_LOADED}:     h.dst = ST_SECURITY_INIT;
			{ST_CONFIG_LOAD, EV_CFG_MISSING}:    h.dst = ST_SETUP;
			{ST_CONFIG_LOAD, EV_CFG_CORRUPT}:    h.dst = ST_ERROR;
			{ST_SECURITY_INIT, EV_SEC_OK}:       h.dst = ST_NET_INIT;
			{ST_SECURITY_INIT, EV_SEC_FAIL}:     h.dst = ST_CRIT;
			{ST_NET_INIT, EV_NETDRV_OK}:         h.dst = ST_SERVICES_INIT;
			{ST_NET_INIT, EV_NETDRV_FAIL}:       h.dst = ST_CRIT;
			{ST_SERVICES_INIT, EV_SVC_OK}:       h.dst = ST_NET_CONNECT;
			{ST_SERVICES_INIT, EV_SVC_FAIL}:     h.dst = ST_CRIT;
			{ST_NET_CONNECT, EV_LINK_UP}:        h.dst = ST_WEB_INIT;
			{ST_NET_CONNECT, EV_LINK_FAIL}:      h.dst = ST_DEGRADED;
			{ST_WEB_INIT, EV_WEB_OK}:            h.dst = ST_RUNNING;
			{ST_WEB_INIT, EV_WEB_FAIL}:          h.dst = ST_ERROR;
			{ST_RUNNING, EV_HEALTH_DEGR}:        h.dst = ST_DEGRADED;
			{ST_RUNNING, EV_HEALTH_CRIT}:        h.dst = ST_CRIT;
			{ST_RUNNING, EV_MAINT_ENTER}:        h.dst = ST_MAINT;
			{ST_RUNNING, EV_SHUTDOWN_REQ}:       h.dst = ST_SHUTDOWN;
			{ST_RUNNING, EV_RESTART_REQ}:        h.dst = ST_RESTART;
			{ST_DEGRADED, EV_HEALTH_OK}:         h.dst = ST_RUNNING;
			{ST_DEGRADED, EV_HEALTH_CRIT}:       h.dst = ST_CRIT;
			{ST_DEGRADED, EV_LINK_UP}:           h.dst = ST_RUNNING;
			{ST_DEGRADED, EV_SHUTDOWN_REQ}:      h.dst = ST_SHUTDOWN;
			{ST_DEGRADED, EV_RESTART_REQ}:       h.dst = ST_RESTART;
			{ST_MAINT, EV_MAINT_EXIT}:           h.dst = ST_RUNNING;
			{ST_MAINT, EV_RESTART_REQ}:          h.dst = ST_RESTART;
			{ST_MAINT, EV_SHUTDOWN_REQ}:         h.dst = ST_SHUTDOWN;
			{ST_ERROR, EV_ERR_RECOVERED}:        h.dst = ST_RUNNING;
			{ST_ERROR, EV_RESTART_REQ}:          h.dst = ST_RESTART;
			{ST_ERROR, EV_SHUTDOWN_REQ}:         h.dst = ST_SHUTDOWN;
			{ST_ERROR, EV_HEALTH_CRIT}:          h.dst = ST_CRIT;
			{ST_CRIT, EV_RESTART_REQ}:           h.dst = ST_RESTART;
			{ST_SETUP, EV_SETUP_DONE}:           h.dst = ST_SECURITY_INIT;
			{ST_SETUP, EV_RESTART_REQ}:          h.dst = ST_RESTART;
			{ST_SETUP, EV_SHUTDOWN_REQ}:         h.dst = ST_SHUTDOWN;
			default:                             h.found = 1'b0;
		endcase
		return h;
	endfunction

	function automatic logic [1:0] notice_for(input logic [STATE_W-1:0] s);
		logic [1:0] n;
		case (s)
			ST_CRIT:     n = NOTE_SYS_ERR;
			ST_RUNNING:  n = NOTE_BOOT_OK;
			ST_RESTART:  n = NOTE_SHUTDOWN;
			ST_SHUTDOWN: n = NOTE_SHUTDOWN;
			default:     n = NOTE_NONE;
		endcase
		return n;
	endfunction

endpackage

@@ design/system_lifecycle_sequencer.sv @@
// Top level of the system lifecycle sequencer: state, counters, result register and skid.
//
// Usage:
//   Input channel (in_valid/in_ready, op, event_code): each beat is either a lifecycle
//   event (op = 0) or one millisecond tick (op = 1).
//   Output channel (out_valid/out_ready and the result fields): exactly one result beat
//   per input beat, in order.
//   Config port (cfg_we, cfg_index, cfg_data): index 0 = critical timeout, index 1 =
//   restart delay, others ignored. Write only while no beats are in flight.
// Results: each is registered in the output register, or in skid when output is held.
// Throughput: one beat per cycle while the skid is empty; the table decode, counter
//   updates and timeout compare are combinational ahead of the result register.
// Stall: a result register plus a one-deep skid register; in_ready falls only when the
//   skid holds a beat, so one more input is taken while a result waits. No beat is lost.
// Reset: state goes to power-on, last state to "none" (17), elapsed time and both
//   counters to zero, timeouts to 10000 and 2000 ms, output and skid empty.
module system_lifecycle_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [sls_pkg::EVENT_W-1:0]   event_code,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          accepted,
	output logic [sls_pkg::STATE_W-1:0]   src_state,
	output logic [sls_pkg::STATE_W-1:0]   dst_state,
	output logic [sls_pkg::STATE_W-1:0]   last_state,
	output logic [sls_pkg::REPORT_W-1:0]  transitions_done,
	output logic [sls_pkg::REPORT_W-1:0]  events_rejected,
	output logic                          operational,
	output logic                          healthy,
	output logic                          restart_now,
	output logic [1:0]                    entry_notice,
	input  logic                          cfg_we,
	input  logic [sls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sls_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sls_pkg::*;

	logic [TIME_W-1:0]      crit_timeout_q;
	logic [TIME_W-1:0]      restart_delay_q;
	logic [STATE_W-1:0]     cur_state_q;
	logic [STATE_W-1:0]     prior_state_q;
	logic [TIME_W-1:0]      elapsed_q;
	logic [COUNT_WIDTH-1:0] trans_q;
	logic [COUNT_WIDTH-1:0] rej_q;

	logic [STATE_W-1:0]     nxt_state;
	logic [STATE_W-1:0]     nxt_prior;
	logic [TIME_W-1:0]      nxt_elapsed;
	logic [COUNT_WIDTH-1:0] nxt_trans;
	logic [COUNT_WIDTH-1:0] nxt_rej;
	logic [REPORT_W-1:0]    trans_rpt;
	logic [REPORT_W-1:0]    rej_rpt;
	hit_t                   hit;
	res_t                   res;
	res_t                   out_q;
	res_t                   skid_q;
	logic                   out_valid_q;
	logic                   skid_valid_q;
	logic                   in_fire;
	logic                   out_fire;

	assign in_ready = !skid_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_timeout_q  <= CRIT_TIMEOUT_RESET;
			restart_delay_q <= RESTART_DELAY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CRIT_TIMEOUT:  crit_timeout_q  <= cfg_data;
				REG_RESTART_DELAY: restart_delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign hit = row_lookup(cur_state_q, event_code);

	always_comb begin
		nxt_state   = cur_state_q;
		nxt_prior   = prior_state_q;
		nxt_elapsed = elapsed_q;
		nxt_trans   = trans_q;
		nxt_rej     = rej_q;
		if (op == OP_TICK) begin
			if (elapsed_q != '1) begin
				nxt_elapsed = elapsed_q + TIME_W'(1);
			end
		end else if (hit.found) begin
			nxt_state   = hit.dst;
			nxt_prior   = cur_state_q;
			nxt_elapsed = '0;
			nxt_trans   = trans_q + COUNT_WIDTH'(1);
		end else begin
			nxt_rej = rej_q + COUNT_WIDTH'(1);
		end
	end

	generate
		if (COUNT_WIDTH >= REPORT_W) begin : g_rpt_trunc
			assign trans_rpt = nxt_trans[REPORT_W-1:0];
			assign rej_rpt   = nxt_rej[REPORT_W-1:0];
		end else begin : g_rpt_ext
			assign trans_rpt = {{(REPORT_W-COUNT_WIDTH){1'b0}}, nxt_trans};
			assign rej_rpt   = {{(REPORT_W-COUNT_WIDTH){1'b0}}, nxt_rej};
		end
	endgenerate

	always_comb begin
		res.accepted         = (op == OP_EVENT) && hit.found;
		res.src_state        = cur_state_q;
		res.dst_state        = nxt_state;
		res.last_state       = nxt_prior;
		res.transitions_done = trans_rpt;
		res.events_rejected  = rej_rpt;
		res.operational      = (nxt_state == ST_RUNNING) || (nxt_state == ST_DEGRADED) ||
		                       (nxt_state == ST_MAINT);
		res.healthy          = (nxt_state != ST_CRIT);
		res.restart_now      = ((nxt_state == ST_CRIT) && (nxt_elapsed > crit_timeout_q)) ||
		                       ((nxt_state == ST_RESTART) && (nxt_elapsed > restart_delay_q));
		res.entry_notice     = res.accepted ? notice_for(nxt_state) : NOTE_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_state_q   <= ST_POWER_ON;
			prior_state_q <= ST_NONE;
			elapsed_q     <= '0;
			trans_q       <= '0;
			rej_q         <= '0;
		end else if (in_fire) begin
			cur_state_q   <= nxt_state;
			prior_state_q <= nxt_prior;
			elapsed_q     <= nxt_elapsed;
			trans_q       <= nxt_trans;
			rej_q         <= nxt_rej;
		end
	end

	// Output register refills from skid first; a new beat lands in skid when output is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_fire) begin
				out_valid_q  <= skid_valid_q || in_fire;
				skid_valid_q <= 1'b0;
			end else if (in_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_fire) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= res;
			end
		end
		if (in_fire && !(!out_valid_q || out_fire)) begin
			skid_q <= res;
		end else if (in_fire && skid_valid_q) begin
			skid_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign accepted         = out_q.accepted;
	assign src_state        = out_q.src_state;
	assign dst_state        = out_q.dst_state;
	assign last_state       = out_q.last_state;
	assign transitions_done = out_q.transitions_done;
	assign events_rejected  = out_q.events_rejected;
	assign operational      = out_q.operational;
	assign healthy          = out_q.healthy;
	assign restart_now      = out_q.restart_now;
	assign entry_notice     = out_q.entry_notice;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat while output register is empty");

	a_state_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> ($stable(cur_state_q) && $stable(trans_q) && $stable(rej_q)))
		else $error("sequencer state moved without an input beat");

	a_trans_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && res.accepted) |=> (trans_q == $past(trans_q) + COUNT_WIDTH'(1)))
		else $error("transition count did not advance on an accepted event");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && out_valid_q && !out_ready) |=> (skid_valid_q && out_valid_q))
		else $error("beat taken during output stall was not parked in skid");

	a_reject_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op == OP_EVENT && !hit.found) |=> $stable(cur_state_q))
		else $error("rejected event changed the state");

endmodule

@@ verif/tb_top.sv @@
// Testbench for system_lifecycle_sequencer: boot, operation, critical error and restart checked per beat.
module tb_top;
	import sls_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 9;
	localparam int LOOP_ITEMS     = 650;
	localparam int PARK_ITEMS     = 78;
	localparam int TIMEOUT_STEPS  = 4;
	localparam int HOLD_CYCLES    = 80;
	localparam int MAX_SHOWN      = 10;
	// Worst honest quiet stretch is the output hold plus a sparse receiver and a sender
	// gap; the watchdog limit is set well above that.
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

	typedef enum int {RX_STREAM, RX_MOSTLY, RX_EVERY_THIRD, RX_SPARSE} rx_mode_e;

	class lifecycle_scoreboard;
		res_t                   pending_reports[$];
		logic [STATE_W-1:0]     cur_state;
		logic [STATE_W-1:0]     prev_state;
		logic [TIME_W-1:0]      elapsed;
		logic [COUNT_WIDTH-1:0] trans_total;
		logic [COUNT_WIDTH-1:0] rej_total;
		logic [TIME_W-1:0]      crit_limit;
		logic [TIME_W-1:0]      delay_limit;
		logic [ST_NONE-1:0]     visited;
		int                     mismatches;
		int                     checked;
		int                     restarts_seen;

		function new();
			cur_state     = ST_POWER_ON;
			prev_state    = ST_NONE;
			elapsed       = '0;
			trans_total   = '0;
			rej_total     = '0;
			crit_limit    = 32'd10000;
			delay_limit   = 32'd2000;
			visited       = '0;
			visited[ST_POWER_ON] = 1'b1;
			mismatches    = 0;
			checked       = 0;
			restarts_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_CRIT_TIMEOUT:  crit_limit = val;
				REG_RESTART_DELAY: delay_limit = val;
				default: ;
			endcase
		endfunction

		// Transition table, grouped by source state.
		function bit lookup_route(logic [STATE_W-1:0] s, logic [EVENT_W-1:0] e,
		                          output logic [STATE_W-1:0] dst);
			dst = s;
			case (s)
				ST_POWER_ON, ST_HW_INIT: begin
					if (e == EV_HW_OK) dst = (s == ST_POWER_ON) ? ST_HW_INIT : ST_STORAGE_INIT;
					else if (e == EV_HW_FAIL) dst = ST_CRIT;
					else return 1'b0;
				end
				ST_STORAGE_INIT: begin
					if (e == EV_STORAGE_OK) dst = ST_CONFIG_LOAD;
					else if (e == EV_STORAGE_FAIL) dst = ST_CRIT;
					else return 1'b0;
				end
				ST_CONFIG_LOAD: begin
					if (e == EV_CFG_LOADED) dst = ST_SECURITY_INIT;
					else if (e == EV_CFG_MISSING) dst = ST_SETUP;
					else if (e == EV_CFG_CORRUPT) dst = ST_ERROR;
					else return 1'b0;
				end
				ST_SECURITY_INIT: begin
					if (e == EV_SEC_OK) dst = ST_NET_INIT;
					else if (e == EV_SEC_FAIL) dst = ST_CRIT;
					else return 1'b0;
				end
				ST_NET_INIT: begin
					if (e == EV_NETDRV_OK) dst = ST_SERVICES_INIT;
					else if (e == EV_NETDRV_FAIL) dst = ST_CRIT;
					else return 1'b0;
				end
				ST_SERVICES_INIT: begin
					if (e == EV_SVC_OK) dst = ST_NET_CONNECT;
					else if (e == EV_SVC_FAIL) dst = ST_CRIT;
					else return 1'b0;
				end
				ST_NET_CONNECT: begin
					if (e == EV_LINK_UP) dst = ST_WEB_INIT;
					else if (e == EV_LINK_FAIL) dst = ST_DEGRADED;
					else return 1'b0;
				end
				ST_WEB_INIT: begin
					if (e == EV_WEB_OK) dst = ST_RUNNING;
					else if (e == EV_WEB_FAIL) dst = ST_ERROR;
					else return 1'b0;
				end
				ST_RUNNING: begin
					if (e == EV_HEALTH_DEGR) dst = ST_DEGRADED;
					else if (e == EV_HEALTH_CRIT) dst = ST_CRIT;
					else if (e == EV_MAINT_ENTER) dst = ST_MAINT;
					else if (e == EV_SHUTDOWN_REQ) dst = ST_SHUTDOWN;
					else if (e == EV_RESTART_REQ) dst = ST_RESTART;
					else return 1'b0;
				end
				ST_DEGRADED: begin
					if (e == EV_HEALTH_OK || e == EV_LINK_UP) dst = ST_RUNNING;
					else if (e == EV_HEALTH_CRIT) dst = ST_CRIT;
					else if (e == EV_SHUTDOWN_REQ) dst = ST_SHUTDOWN;
					else if (e == EV_RESTART_REQ) dst = ST_RESTART;
					else return 1'b0;
				end
				ST_MAINT: begin
					if (e == EV_MAINT_EXIT) dst = ST_RUNNING;
					else if (e == EV_RESTART_REQ) dst = ST_RESTART;
					else if (e == EV_SHUTDOWN_REQ) dst = ST_SHUTDOWN;
					else return 1'b0;
				end
				ST_ERROR: begin
					if (e == EV_ERR_RECOVERED) dst = ST_RUNNING;
					else if (e == EV_RESTART_REQ) dst = ST_RESTART;
					else if (e == EV_SHUTDOWN_REQ) dst = ST_SHUTDOWN;
					else if (e == EV_HEALTH_CRIT) dst = ST_CRIT;
					else return 1'b0;
				end
				ST_CRIT: begin
					if (e == EV_RESTART_REQ) dst = ST_RESTART;
					else return 1'b0;
				end
				ST_SETUP: begin
					if (e == EV_SETUP_DONE) dst = ST_SECURITY_INIT;
					else if (e == EV_RESTART_REQ) dst = ST_RESTART;
					else if (e == EV_SHUTDOWN_REQ) dst = ST_SHUTDOWN;
					else return 1'b0;
				end
				default: return 1'b0;
			endcase
			return 1'b1;
		endfunction

		function void predict_beat(logic o, logic [EVENT_W-1:0] e);
			res_t               r;
			logic [STATE_W-1:0] dst;
			r = '0;
			r.src_state = cur_state;
			if (o == OP_TICK) begin
				if (elapsed != '1) elapsed = elapsed + 1'b1;
			end else if (lookup_route(cur_state, e, dst)) begin
				prev_state  = cur_state;
				cur_state   = dst;
				elapsed     = '0;
				trans_total = trans_total + 1'b1;
				r.accepted  = 1'b1;
				case (dst)
					ST_CRIT:                 r.entry_notice = NOTE_SYS_ERR;
					ST_RUNNING:              r.entry_notice = NOTE_BOOT_OK;
					ST_RESTART, ST_SHUTDOWN: r.entry_notice = NOTE_SHUTDOWN;
					default:                 r.entry_notice = NOTE_NONE;
				endcase
			end else begin
				rej_total = rej_total + 1'b1;
			end
			r.dst_state        = cur_state;
			r.last_state       = prev_state;
			r.transitions_done = trans_total[REPORT_W-1:0];
			r.events_rejected  = rej_total[REPORT_W-1:0];
			r.operational      = (cur_state == ST_RUNNING) || (cur_state == ST_DEGRADED) ||
			                     (cur_state == ST_MAINT);
			r.healthy          = (cur_state != ST_CRIT);
			r.restart_now      = ((cur_state == ST_CRIT) && (elapsed > crit_limit)) ||
			                     ((cur_state == ST_RESTART) && (elapsed > delay_limit));
			if (r.restart_now) restarts_seen++;
			visited[cur_state] = 1'b1;
			pending_reports.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("result %0d: %s expected %0d, got %0d", checked, name, want, got);
			end
		endfunction

		function void check_report(res_t got);
			res_t want;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("result beat with nothing expected (dst_state %0d)", got.dst_state);
				return;
			end
			want = pending_reports.pop_front();
			checked++;
			compare_field("accepted", want.accepted, got.accepted);
			compare_field("src_state", want.src_state, got.src_state);
			compare_field("dst_state", want.dst_state, got.dst_state);
			compare_field("last_state", want.last_state, got.last_state);
			compare_field("transitions_done", want.transitions_done, got.transitions_done);
			compare_field("events_rejected", want.events_rejected, got.events_rejected);
			compare_field("operational", want.operational, got.operational);
			compare_field("healthy", want.healthy, got.healthy);
			compare_field("restart_now", want.restart_now, got.restart_now);
			compare_field("entry_notice", want.entry_notice, got.entry_notice);
		endfunction
	endclass

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  op         = OP_EVENT;
	logic [EVENT_W-1:0]    event_code = '0;
	logic                  out_ready  = 1'b0;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_ready;
	logic                  out_valid;
	logic                  accepted;
	logic [STATE_W-1:0]    src_state;
	logic [STATE_W-1:0]    dst_state;
	logic [STATE_W-1:0]    last_state;
	logic [REPORT_W-1:0]   transitions_done;
	logic [REPORT_W-1:0]   events_rejected;
	logic                  operational;
	logic                  healthy;
	logic                  restart_now;
	logic [1:0]            entry_notice;

	lifecycle_scoreboard chk = new();
	res_t     observed;
	rx_mode_e rx_mode = RX_STREAM;
	int       mode_left = 0;
	int       rx_count = 0;
	int       hold_trigger = 0;
	int       hold_seen = 0;
	int       hold_left = 0;
	int       burst_left = 0;
	int       beats_sent = 0;
	int       quiet_cycles = 0;

	system_lifecycle_sequencer u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op),
		.event_code       (event_code),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.accepted         (accepted),
		.src_state        (src_state),
		.dst_state        (dst_state),
		.last_state       (last_state),
		.transitions_done (transitions_done),
		.events_rejected  (events_rejected),
		.operational      (operational),
		.healthy          (healthy),
		.restart_now      (restart_now),
		.entry_notice     (entry_notice),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Result side: check accepted beats, then pick next ready from the stall pattern.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				observed.accepted         = accepted;
				observed.src_state        = src_state;
				observed.dst_state        = dst_state;
				observed.last_state       = last_state;
				observed.transitions_done = transitions_done;
				observed.events_rejected  = events_rejected;
				observed.operational      = operational;
				observed.healthy          = healthy;
				observed.restart_now      = restart_now;
				observed.entry_notice     = entry_notice;
				chk.check_report(observed);
			end
			if (hold_trigger != hold_seen) begin
				hold_seen = hold_trigger;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				rx_mode   = rx_mode_e'($urandom_range(3));
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			rx_count++;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_STREAM:      out_ready <= 1'b1;
					RX_MOSTLY:      out_ready <= ($urandom_range(3) != 0);
					RX_EVERY_THIRD: out_ready <= (rx_count % 3 == 0);
					default:        out_ready <= ($urandom_range(9) < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", quiet_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// Called at a rising edge; returns at the edge where the beat is taken.
	task automatic send_item(input logic o, input logic [EVENT_W-1:0] e);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		op         <= o;
		event_code <= e;
		do @(posedge clk); while (!in_ready);
		chk.predict_beat(o, e);
		beats_sent++;
	endtask

	task automatic wait_idle();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (chk.pending_reports.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Writes both timeouts plus junk to the unused indexes, which must be ignored.
	task automatic program_regs(input logic [CFG_DATA_W-1:0] crit_ms,
	                            input logic [CFG_DATA_W-1:0] delay_ms);
		logic [CFG_DATA_W-1:0] vals [1 << CFG_IDX_W];
		vals[REG_CRIT_TIMEOUT]  = crit_ms;
		vals[REG_RESTART_DELAY] = delay_ms;
		vals[REG_UNUSED_LO]     = $urandom;
		vals[REG_UNUSED_HI]     = $urandom;
		for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data  <= vals[i];
			@(posedge clk);
			chk.write_reg(i[CFG_IDX_W-1:0], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// Event that keeps a healthy system moving: boot forward, then loop among
	// running, degraded and maintenance.
	function automatic logic [EVENT_W-1:0] next_step_event(input logic [STATE_W-1:0] s);
		case (s)
			ST_POWER_ON, ST_HW_INIT: return EV_HW_OK;
			ST_STORAGE_INIT:  return EV_STORAGE_OK;
			ST_CONFIG_LOAD: begin
				case ($urandom_range(2))
					0:       return EV_CFG_LOADED;
					1:       return EV_CFG_MISSING;
					default: return EV_CFG_CORRUPT;
				endcase
			end
			ST_SECURITY_INIT: return EV_SEC_OK;
			ST_NET_INIT:      return EV_NETDRV_OK;
			ST_SERVICES_INIT: return EV_SVC_OK;
			ST_NET_CONNECT:   return $urandom_range(1) ? EV_LINK_UP : EV_LINK_FAIL;
			ST_WEB_INIT:      return $urandom_range(1) ? EV_WEB_OK : EV_WEB_FAIL;
			ST_SETUP:         return EV_SETUP_DONE;
			ST_RUNNING:       return $urandom_range(1) ? EV_HEALTH_DEGR : EV_MAINT_ENTER;
			ST_DEGRADED:      return $urandom_range(1) ? EV_HEALTH_OK : EV_LINK_UP;
			ST_MAINT:         return EV_MAINT_EXIT;
			ST_ERROR:         return EV_ERR_RECOVERED;
			default:          return EV_HW_OK;
		endcase
	endfunction

	// Mostly well-formed traffic; noise that would fall into a dead-end state
	// (critical, shutdown, restart) is turned into a tick.
	task automatic loop_item();
		logic [EVENT_W-1:0] ev;
		logic [STATE_W-1:0] dst;
		int                 pick;
		pick = $urandom_range(99);
		ev   = EVENT_W'($urandom_range(31));
		if (pick < 55)
			send_item(OP_EVENT, next_step_event(chk.cur_state));
		else if (pick < 80 || (chk.lookup_route(chk.cur_state, ev, dst) &&
		         (dst == ST_CRIT || dst == ST_SHUTDOWN || dst == ST_RESTART)))
			send_item(OP_TICK, ev);
		else
			send_item(OP_EVENT, ev);
	endtask

	// Mostly ticks while parked in a state; the one way out is never sent.
	task automatic parked_item();
		logic [EVENT_W-1:0] ev;
		ev = EVENT_W'($urandom_range(31));
		if ($urandom_range(9) < 7 || ev == EV_RESTART_REQ) send_item(OP_TICK, ev);
		else send_item(OP_EVENT, ev);
	endtask

	function automatic logic [TIME_W-1:0] timeout_choice(input int step,
	                                                     input logic [TIME_W-1:0] now);
		case (step)
			0:       return '1;
			1:       return now + $urandom_range(2, 30);
			2:       return '0;
			default: return now + $urandom_range(40, 70);
		endcase
	endfunction

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values, unknown codes, an unrouted event, boot, operational moves
		send_item(OP_TICK, '1);
		send_item(OP_EVENT, '1);
		send_item(OP_EVENT, EV_SETUP_DONE + 1'b1);
		send_item(OP_EVENT, EV_SHUTDOWN_REQ);
		send_item(OP_TICK, '0);
		while (chk.cur_state != ST_RUNNING) send_item(OP_EVENT, next_step_event(chk.cur_state));
		send_item(OP_EVENT, EV_MAINT_ENTER);
		send_item(OP_EVENT, EV_HEALTH_CRIT);
		send_item(OP_EVENT, EV_MAINT_EXIT);
		send_item(OP_EVENT, EV_HEALTH_DEGR);
		send_item(OP_EVENT, EV_LINK_UP);
		send_item(OP_TICK, EV_HEALTH_CRIT);
		wait_idle();

		program_regs('0, '1);
		hold_trigger++;
		repeat (LOOP_ITEMS) loop_item();
		wait_idle();
		program_regs('1, '0);
		repeat (LOOP_ITEMS) loop_item();

		while (chk.cur_state != ST_CRIT) begin
			if (chk.cur_state == ST_RUNNING || chk.cur_state == ST_DEGRADED ||
			    chk.cur_state == ST_ERROR)
				send_item(OP_EVENT, EV_HEALTH_CRIT);
			else
				send_item(OP_EVENT, next_step_event(chk.cur_state));
		end
		wait_idle();
		for (int k = 0; k < TIMEOUT_STEPS; k++) begin
			program_regs(timeout_choice(k, chk.elapsed), chk.delay_limit);
			repeat (PARK_ITEMS) parked_item();
			wait_idle();
		end

		send_item(OP_EVENT, EV_RESTART_REQ);
		wait_idle();
		for (int k = 0; k < TIMEOUT_STEPS; k++) begin
			program_regs(chk.crit_limit, timeout_choice(k, chk.elapsed));
			if (k == 0) hold_trigger++;
			repeat (PARK_ITEMS) parked_item();
			wait_idle();
		end
		repeat (4) @(posedge clk);

		$display("Run covered %0d input beats, %0d results checked, %0d transitions, %0d rejected.",
		         beats_sent, chk.checked, chk.trans_total, chk.rej_total);
		$display("%0d lifecycle states reached, restart flag expected on %0d results.",
		         $countones(chk.visited), chk.restarts_seen);
		if (chk.mismatches == 0 && chk.pending_reports.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d results missing", chk.mismatches,
			         chk.pending_reports.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/sls_pkg.sv
design/system_lifecycle_sequencer.sv
verif/tb_top.sv
